FILE: rtl/core/prefixed_length_frame_receiver_unit_assert.svh
// Assertion macros for the frame receiver back end (plfr_back).
`ifndef PREFIXED_LENGTH_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define PREFIXED_LENGTH_FRAME_RECEIVER_UNIT_ASSERT_SVH

// Check a property on every rising edge outside reset.
`define PLFR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define PLFR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/plfr_pkg.sv
package plfr_pkg;

    localparam int MAX_FRAME = 64;
    localparam int MIN_FRAME = 4;
    localparam int Q_DEPTH   = 2;

    localparam logic [7:0]  START_BYTE   = 8'h53;
    localparam logic [7:0]  SUFFIX_BYTE  = 8'h45;
    localparam logic [8:0]  LEN_OVERHEAD = 9'd2;
    localparam logic [15:0] TIMEOUT_RST  = 16'd100;

    localparam logic [3:0] EV_NONE      = 4'd0;
    localparam logic [3:0] EV_STORED    = 4'd1;
    localparam logic [3:0] EV_GOOD      = 4'd2;
    localparam logic [3:0] EV_BADSUFFIX = 4'd3;
    localparam logic [3:0] EV_DROPPED   = 4'd4;
    localparam logic [3:0] EV_OVERFLOW  = 4'd5;
    localparam logic [3:0] EV_TIMEOUT   = 4'd6;
    localparam logic [3:0] EV_HOLDEND   = 4'd7;
    localparam logic [3:0] EV_IGNORED   = 4'd8;

    typedef struct packed {
        logic        func;
        logic [7:0]  rx_byte;
        logic [31:0] now_ms;
    } t_req;

    typedef struct packed {
        logic [3:0] event_res;
        logic [7:0] out_byte;
        logic [5:0] byte_pos;
        logic [8:0] frame_len;
    } t_rsp;

    // Classified request handed from front to back.
    typedef struct packed {
        logic        is_tick;
        logic        is_start;
        logic        is_suffix;
        logic [7:0]  rx_byte;
        logic [31:0] now_ms;
        logic [31:0] deadline_ms;
    } t_cmd;

endpackage

FILE: rtl/core/plfr_front.sv
module plfr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_data,
    input  plfr_pkg::t_req    i_req,
    output plfr_pkg::t_cmd    o_cmd
);

    logic [15:0] r_timeout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= plfr_pkg::TIMEOUT_RST;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_data;
        end
    end

    // Classify the request and precompute the candidate deadline.
    always_comb begin
        o_cmd.is_tick     = i_req.func;
        o_cmd.is_start    = (i_req.rx_byte == plfr_pkg::START_BYTE);
        o_cmd.is_suffix   = (i_req.rx_byte == plfr_pkg::SUFFIX_BYTE);
        o_cmd.rx_byte     = i_req.rx_byte;
        o_cmd.now_ms      = i_req.now_ms;
        o_cmd.deadline_ms = i_req.now_ms + 32'(r_timeout);
    end

endmodule

FILE: rtl/core/plfr_queue.sv
module plfr_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  plfr_pkg::t_cmd    i_data,
    output logic              o_full,
    output logic              o_valid,
    output plfr_pkg::t_cmd    o_data,
    input  logic              i_pop
);

    localparam int PTR_W = $clog2(plfr_pkg::Q_DEPTH);
    localparam int CNT_W = $clog2(plfr_pkg::Q_DEPTH + 1);

    plfr_pkg::t_cmd   r_mem [plfr_pkg::Q_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(plfr_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(plfr_pkg::Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(plfr_pkg::Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

FILE: rtl/core/plfr_back.sv
`include "prefixed_length_frame_receiver_unit_assert.svh"

module plfr_back #(
    parameter int MAX_FRAME = plfr_pkg::MAX_FRAME,
    parameter int MIN_FRAME = plfr_pkg::MIN_FRAME
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  plfr_pkg::t_cmd    i_cmd,
    output logic              o_pop,
    output logic              o_valid,
    output plfr_pkg::t_rsp    o_rsp,
    input  logic              i_stall
);

    localparam int IDX_W = $clog2(MAX_FRAME + 1);
    localparam int CMP_W = 10;

    logic             r_holdoff, n_holdoff;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [8:0]       r_exp, n_exp;
    logic [31:0]      r_deadline, n_deadline;
    logic             r_timer, n_timer;
    logic             r_valid;
    plfr_pkg::t_rsp   r_rsp, n_rsp;

    logic [31:0]      dl_diff;
    logic             dl_passed;
    logic [CMP_W-1:0] idx_inc;

    assign o_pop   = i_valid && (!r_valid || !i_stall);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    assign dl_diff   = i_cmd.now_ms - r_deadline;
    assign dl_passed = (dl_diff != '0) && !dl_diff[31];
    assign idx_inc   = CMP_W'(r_idx) + CMP_W'(1);

    always_comb begin
        n_holdoff  = r_holdoff;
        n_idx      = r_idx;
        n_exp      = r_exp;
        n_deadline = r_deadline;
        n_timer    = r_timer;
        n_rsp      = '0;
        if (i_cmd.is_tick) begin
            if (r_holdoff) begin
                if (dl_passed) begin
                    n_holdoff       = 1'b0;
                    n_rsp.event_res = plfr_pkg::EV_HOLDEND;
                end else begin
                    n_rsp.event_res = plfr_pkg::EV_NONE;
                end
            end else if (r_timer && dl_passed) begin
                n_idx           = '0;
                n_exp           = '0;
                n_timer         = 1'b0;
                n_deadline      = i_cmd.deadline_ms;
                n_holdoff       = 1'b1;
                n_rsp.event_res = plfr_pkg::EV_TIMEOUT;
            end else begin
                n_rsp.event_res = plfr_pkg::EV_NONE;
            end
        end else if (r_holdoff) begin
            n_rsp.event_res = plfr_pkg::EV_IGNORED;
        end else if (r_idx >= IDX_W'(MAX_FRAME)) begin
            n_idx           = '0;
            n_exp           = '0;
            n_rsp.event_res = plfr_pkg::EV_OVERFLOW;
        end else if ((r_idx == '0) && !i_cmd.is_start) begin
            n_exp           = 9'(MIN_FRAME);
            n_rsp.event_res = plfr_pkg::EV_DROPPED;
        end else begin
            if (r_idx == '0) begin
                n_exp   = 9'(MIN_FRAME);
                n_timer = 1'b1;
            end else if (r_idx == IDX_W'(1)) begin
                n_exp = 9'(i_cmd.rx_byte) + plfr_pkg::LEN_OVERHEAD;
            end
            n_deadline      = i_cmd.deadline_ms;
            n_idx           = IDX_W'(idx_inc);
            n_rsp.event_res = plfr_pkg::EV_STORED;
            // Close the frame when the count reaches the expected size.
            if (idx_inc == CMP_W'(n_exp)) begin
                n_idx           = '0;
                n_timer         = 1'b0;
                n_rsp.event_res = i_cmd.is_suffix ? plfr_pkg::EV_GOOD
                                                  : plfr_pkg::EV_BADSUFFIX;
            end
            n_rsp.out_byte  = i_cmd.rx_byte;
            n_rsp.byte_pos  = 6'(r_idx);
            n_rsp.frame_len = n_exp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holdoff  <= 1'b0;
            r_idx      <= '0;
            r_exp      <= '0;
            r_deadline <= '0;
            r_timer    <= 1'b0;
            r_valid    <= 1'b0;
        end else if (o_pop) begin
            r_holdoff  <= n_holdoff;
            r_idx      <= n_idx;
            r_exp      <= n_exp;
            r_deadline <= n_deadline;
            r_timer    <= n_timer;
            r_valid    <= 1'b1;
        end else if (!i_stall) begin
            r_valid    <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rsp <= n_rsp;
        end
    end

    `PLFR_ASSERT(a_idx_range, i_clk, i_rst_n, (r_idx <= IDX_W'(MAX_FRAME)), "frame index past buffer size")
    `PLFR_ASSERT(a_holdoff_timer, i_clk, i_rst_n, (r_holdoff |-> !r_timer), "timer running during hold-off")
    `PLFR_ASSERT(a_frame_timer, i_clk, i_rst_n, ((r_idx != '0) |-> (r_timer && (r_exp != '0))), "open frame without timer or size")

endmodule

FILE: rtl/core/prefixed_length_frame_receiver_unit.sv
// Length-prefixed frame receiver.
// Input channel: i_valid / o_stall carry one request (i_req): a received byte
// (func 0) or a time check tick (func 1), each with the current ms time.
// Output channel: o_valid / i_stall carry exactly one response (o_rsp) per
// request, in order: an event code, and for stored bytes the byte, its
// position and the expected frame size.
// Configuration: i_cfg_we / i_cfg_data write the 16-bit timeout; write it
// only while no request is in flight.
// Path: an accepted request is written into the queue; the back end then
// pops it and registers the response in the output register.
// Throughput: one request per cycle; the back end updates frame state once
// per request as it pops it, and the two-entry queue plus output register
// keep a request flowing every cycle while the receiver is ready.
// Stall: a stalled response holds in the output register; the queue absorbs
// up to two more requests, then o_stall rises.
// Reset: synchronous, active low; clears the queue, the output valid and
// all frame state, and restores the timeout to 100 ms.
module prefixed_length_frame_receiver_unit #(
    parameter int MAX_FRAME = plfr_pkg::MAX_FRAME,
    parameter int MIN_FRAME = plfr_pkg::MIN_FRAME
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  plfr_pkg::t_req    i_req,
    output logic              o_valid,
    input  logic              i_stall,
    output plfr_pkg::t_rsp    o_rsp,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_data
);

    plfr_pkg::t_cmd front_cmd;
    plfr_pkg::t_cmd q_cmd;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;
    logic           push;

    // Take a request whenever the queue has room.
    assign o_stall = q_full;
    assign push    = i_valid && !q_full;

    // Classify the request and precompute its deadline.
    plfr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (i_req),
        .o_cmd      (front_cmd)
    );

    // Decouple front from back so either side can stall alone.
    plfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_cmd),
        .i_pop   (q_pop)
    );

    // Advance the frame state and register the response.
    plfr_back #(
        .MAX_FRAME (MAX_FRAME),
        .MIN_FRAME (MIN_FRAME)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (q_cmd),
        .o_pop   (q_pop),
        .o_valid (o_valid),
        .o_rsp   (o_rsp),
        .i_stall (i_stall)
    );

endmodule

FILE: tb/prefixed_length_frame_receiver_unit_tb.sv
`timescale 1ns / 1ps

module prefixed_length_frame_receiver_unit_tb;

    localparam int IDLE_LIMIT = 2000;

    logic           i_clk;
    logic           i_rst_n    = 1'b0;
    logic           i_valid    = 1'b0;
    logic           o_stall;
    plfr_pkg::t_req i_req      = '0;
    logic           o_valid;
    logic           i_stall    = 1'b0;
    plfr_pkg::t_rsp o_rsp;
    logic           i_cfg_we   = 1'b0;
    logic [15:0]    i_cfg_data = '0;

    prefixed_length_frame_receiver_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Receiver-side copy of the frame state.
    logic        hold_active     = 1'b0;
    logic [6:0]  frame_index     = '0;
    logic [8:0]  frame_size      = '0;
    logic [31:0] frame_deadline  = '0;
    logic        frame_timer_on  = 1'b0;
    logic [15:0] timeout_setting = plfr_pkg::TIMEOUT_RST;

    plfr_pkg::t_rsp pending_events[$];
    plfr_pkg::t_rsp oldest_event;
    logic [31:0] clock_ms        = '0;
    int          sent_requests   = 0;
    int          fail_count      = 0;
    int          send_idle_pct   = 0;
    int          stall_pct       = 0;
    int          rsp_hold_cycles = 0;
    int          quiet_cycles    = 0;

    function automatic logic [7:0] random_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Wrap-safe: passed when now - deadline lies in 1 .. 2^31-1.
    function automatic bit deadline_passed(input logic [31:0] now);
        logic [31:0] gap;
        gap = now - frame_deadline;
        return (gap != 32'd0) && !gap[31];
    endfunction

    function automatic plfr_pkg::t_rsp predict_event(input plfr_pkg::t_req r);
        plfr_pkg::t_rsp rsp;
        logic [6:0]     pos;
        rsp = '0;
        rsp.event_res = plfr_pkg::EV_NONE;
        if (r.func) begin
            if (hold_active) begin
                if (deadline_passed(r.now_ms)) begin
                    hold_active   = 1'b0;
                    rsp.event_res = plfr_pkg::EV_HOLDEND;
                end
            end else if (frame_timer_on && deadline_passed(r.now_ms)) begin
                frame_index    = '0;
                frame_size     = '0;
                frame_timer_on = 1'b0;
                frame_deadline = r.now_ms + {16'd0, timeout_setting};
                hold_active    = 1'b1;
                rsp.event_res  = plfr_pkg::EV_TIMEOUT;
            end
            return rsp;
        end
        if (hold_active) begin
            rsp.event_res = plfr_pkg::EV_IGNORED;
            return rsp;
        end
        if (frame_index >= plfr_pkg::MAX_FRAME) begin
            frame_index   = '0;
            frame_size    = '0;
            rsp.event_res = plfr_pkg::EV_OVERFLOW;
            return rsp;
        end
        if (frame_index == 7'd0) begin
            frame_size = 9'(plfr_pkg::MIN_FRAME);
            if (r.rx_byte != plfr_pkg::START_BYTE) begin
                rsp.event_res = plfr_pkg::EV_DROPPED;
                return rsp;
            end
            frame_timer_on = 1'b1;
        end else if (frame_index == 7'd1) begin
            frame_size = {1'b0, r.rx_byte} + plfr_pkg::LEN_OVERHEAD;
        end
        frame_deadline = r.now_ms + {16'd0, timeout_setting};
        pos            = frame_index;
        frame_index    = frame_index + 7'd1;
        rsp.event_res  = plfr_pkg::EV_STORED;
        if ({2'b00, frame_index} == frame_size) begin
            frame_index    = '0;
            frame_timer_on = 1'b0;
            rsp.event_res  = (r.rx_byte == plfr_pkg::SUFFIX_BYTE) ? plfr_pkg::EV_GOOD
                                                                   : plfr_pkg::EV_BADSUFFIX;
        end
        rsp.out_byte  = r.rx_byte;
        rsp.byte_pos  = pos[5:0];
        rsp.frame_len = frame_size;
        return rsp;
    endfunction

    // Advance the time base by dt, offer one request and hold it until taken.
    task automatic send_request(input logic func, input logic [7:0] b, input logic [31:0] dt);
        plfr_pkg::t_req r;
        plfr_pkg::t_rsp rsp;
        clock_ms  = clock_ms + dt;
        r.func    = func;
        r.rx_byte = b;
        r.now_ms  = clock_ms;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_req   = r;
        do @(posedge i_clk); while (o_stall);
        rsp = predict_event(r);
        pending_events.push_back(rsp);
        sent_requests++;
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every predicted event has come back.
    task automatic drain();
        i_valid = 1'b0;
        while (pending_events.size() != 0) @(negedge i_clk);
    endtask

    task automatic set_timeout(input logic [15:0] value);
        drain();
        i_cfg_we   = 1'b1;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we        = 1'b0;
        timeout_setting = value;
    endtask

    // Prefix, length, body, suffix; a length past the buffer runs into overflow.
    task automatic send_frame(input logic [7:0] len, input logic [7:0] suffix);
        int         total;
        logic [7:0] b;
        total = (len + 2 > plfr_pkg::MAX_FRAME) ? plfr_pkg::MAX_FRAME + 1 : len + 2;
        for (int k = 0; k < total; k++) begin
            if (k == 0) b = plfr_pkg::START_BYTE;
            else if (k == 1) b = len;
            else if (k == len + 1) b = suffix;
            else b = random_byte();
            send_request(1'b0, b, $urandom_range(0, 2));
            if ($urandom_range(99) < 8) send_request(1'b1, random_byte(), $urandom_range(0, 1));
        end
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        fail_count++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    endtask

    // Compare every response taken by the receiver with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_events.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected response, expected none, got %h", $time, o_rsp);
            end else begin
                oldest_event = pending_events.pop_front();
                if (o_rsp.event_res !== oldest_event.event_res)
                    report_mismatch("event_res", oldest_event.event_res, o_rsp.event_res);
                if (o_rsp.out_byte !== oldest_event.out_byte)
                    report_mismatch("out_byte", oldest_event.out_byte, o_rsp.out_byte);
                if (o_rsp.byte_pos !== oldest_event.byte_pos)
                    report_mismatch("byte_pos", oldest_event.byte_pos, o_rsp.byte_pos);
                if (o_rsp.frame_len !== oldest_event.frame_len)
                    report_mismatch("frame_len", oldest_event.frame_len, o_rsp.frame_len);
            end
        end
    end

    // Receiver: a forced hold-off first, otherwise random stalls.
    always @(negedge i_clk) begin
        if (rsp_hold_cycles > 0) begin
            i_stall = 1'b1;
            rsp_hold_cycles--;
        end else begin
            i_stall = ($urandom_range(99) < stall_pct);
        end
    end

    // Abort when neither channel moves for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic test_idle_ticks();
        clock_ms = 32'd0;
        send_request(1'b1, 8'h00, 32'd0);
        clock_ms = 32'hFFFF_FFFF;
        send_request(1'b1, 8'hFF, 32'd0);
        send_request(1'b0, 8'h00, 32'd0);
        send_request(1'b0, 8'hFF, 32'd1);
    endtask

    task automatic test_frames();
        send_frame(8'd2, plfr_pkg::SUFFIX_BYTE);
        send_frame(8'd1, 8'h44);
        // length zero: the length byte itself closes the frame
        send_frame(8'd0, plfr_pkg::SUFFIX_BYTE);
    endtask

    task automatic test_overflow();
        send_frame(8'hFF, plfr_pkg::SUFFIX_BYTE);
    endtask

    task automatic test_timeout_holdoff();
        set_timeout(plfr_pkg::TIMEOUT_RST);
        send_request(1'b0, plfr_pkg::START_BYTE, 32'd5);
        send_request(1'b1, random_byte(), 32'd100);
        send_request(1'b1, random_byte(), 32'd1);
        send_request(1'b0, plfr_pkg::START_BYTE, 32'd0);
        send_request(1'b1, random_byte(), 32'd100);
        send_request(1'b1, random_byte(), 32'd1);
        // half a time range away is not passed; one step short of it is
        send_request(1'b0, plfr_pkg::START_BYTE, 32'd3);
        send_request(1'b1, random_byte(), 32'h8000_0000 + 32'd100);
        send_request(1'b1, random_byte(), 32'hFFFF_FFFF);
        send_request(1'b1, random_byte(), 32'd101);
    endtask

    task automatic test_timeout_extremes();
        set_timeout(16'd0);
        send_request(1'b0, plfr_pkg::START_BYTE, 32'd0);
        send_request(1'b1, random_byte(), 32'd0);
        send_request(1'b1, random_byte(), 32'd1);
        send_request(1'b1, random_byte(), 32'd0);
        send_request(1'b1, random_byte(), 32'd1);
        set_timeout(16'hFFFF);
        send_request(1'b0, plfr_pkg::START_BYTE, 32'd0);
        send_request(1'b1, random_byte(), 32'd65535);
        send_request(1'b1, random_byte(), 32'd1);
        send_request(1'b0, plfr_pkg::START_BYTE, 32'd0);
        send_request(1'b1, random_byte(), 32'd65536);
    endtask

    task automatic test_wrap();
        set_timeout(plfr_pkg::TIMEOUT_RST);
        clock_ms = 32'hFFFF_FFC0;
        send_request(1'b0, plfr_pkg::START_BYTE, 32'd0);
        send_request(1'b1, random_byte(), 32'd100);
        send_request(1'b1, random_byte(), 32'd1);
        send_request(1'b1, random_byte(), 32'd101);
        clock_ms = 32'hFFFF_FFFE;
        send_frame(8'd3, plfr_pkg::SUFFIX_BYTE);
    endtask

    // Hold the receiver off so the queue fills and the input stalls.
    task automatic test_backpressure();
        send_idle_pct   = 0;
        stall_pct       = 0;
        rsp_hold_cycles = 60;
        send_frame(8'd12, plfr_pkg::SUFFIX_BYTE);
        drain();
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_in,
                                    input logic [15:0] tmo, input int n);
        int          target;
        int          pick;
        logic [7:0]  len;
        logic [31:0] dt;
        set_timeout(tmo);
        send_idle_pct = idle_pct;
        stall_pct     = stall_in;
        target        = sent_requests + n;
        while (sent_requests < target) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                len = ($urandom_range(9) == 0) ? 8'($urandom_range(21, 70))
                                               : 8'($urandom_range(0, 20));
                if ($urandom_range(29) == 0) len = random_byte();
                send_frame(len, ($urandom_range(99) < 85) ? plfr_pkg::SUFFIX_BYTE
                                                          : random_byte());
            end else if (pick < 68) begin
                // truncated frame, then silence long enough to abort it
                send_request(1'b0, plfr_pkg::START_BYTE, 32'd1);
                repeat ($urandom_range(0, 4)) send_request(1'b0, random_byte(), 32'd1);
                send_request(1'b1, random_byte(),
                             {16'd0, timeout_setting} + $urandom_range(1, 2));
                repeat ($urandom_range(0, 3)) send_request(1'b0, random_byte(), 32'd0);
            end else if (pick < 85) begin
                // step to just before, at or past the deadline
                if ($urandom_range(3) == 0) dt = {16'd0, timeout_setting} + $urandom_range(0, 2);
                else dt = $urandom_range(0, 2);
                send_request(1'b1, random_byte(), dt);
            end else if (pick < 93) begin
                send_request(1'b0, random_byte(), $urandom_range(0, 3));
            end else begin
                clock_ms = $urandom();
                send_request(1'($urandom_range(0, 1)), random_byte(), 32'd0);
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_idle_ticks();
        test_frames();
        test_overflow();
        test_timeout_holdoff();
        test_timeout_extremes();
        test_wrap();
        test_backpressure();
        run_random_phase(0, 0, plfr_pkg::TIMEOUT_RST, 330);
        run_random_phase(59, 0, 16'd1, 330);
        run_random_phase(0, 59, 16'hFFFF, 330);
        run_random_phase(35, 35, 16'($urandom_range(2, 300)), 330);

        drain();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/plfr_pkg.sv
rtl/core/plfr_front.sv
rtl/core/plfr_queue.sv
rtl/core/plfr_back.sv
rtl/core/prefixed_length_frame_receiver_unit.sv
tb/prefixed_length_frame_receiver_unit_tb.sv
